// ----- design/bcv_pkg.sv -----
// Shared types, widths and the discharge curve of the battery charge converter.
`timescale 1ns / 1ps
`default_nettype none

package bcv_pkg;

  localparam int CURVE_POINTS = 18;
  localparam int SEGMENTS     = CURVE_POINTS - 1;
  localparam int PT_W         = $clog2(CURVE_POINTS);
  localparam int SEG_W        = $clog2(SEGMENTS);

  localparam int MV_W         = 13;
  localparam int PCT_W        = 7;
  localparam int OFF_W        = 7;
  localparam int N_W          = 16;
  localparam int RECIP_W      = 12;
  localparam int RECIP_SHIFT  = 18;
  localparam int PROD_W       = N_W + RECIP_W;

  localparam int QUEUE_DEPTH  = 4;

  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

  typedef logic [MV_W-1:0]    mv_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [RECIP_W-1:0] recip_t;

  localparam mv_t CURVE_MV [CURVE_POINTS] = '{
    13'd3300, 13'd3350, 13'd3400, 13'd3450, 13'd3500, 13'd3550,
    13'd3600, 13'd3650, 13'd3700, 13'd3750, 13'd3800, 13'd3850,
    13'd3900, 13'd3950, 13'd4000, 13'd4050, 13'd4100, 13'd4160
  };

  localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
    7'd0,  7'd1,  7'd2,  7'd6,  7'd10, 7'd15,
    7'd19, 7'd22, 7'd27, 7'd33, 7'd42, 7'd53,
    7'd63, 7'd70, 7'd81, 7'd93, 7'd98, 7'd100
  };

  // Rounded-up reciprocal of twice each segment's width, scaled by two to the RECIP_SHIFT.
  localparam recip_t SEG_RECIP [SEGMENTS] = '{
    12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2622,
    12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2622,
    12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2185
  };

  typedef enum logic [1:0] {
    KIND_SEG  = 2'd0,
    KIND_LOW  = 2'd1,
    KIND_HIGH = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEG_W-1:0]  seg;
    logic [OFF_W-1:0]  off;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/bcv_in_if.sv -----
// Channel interface that carries millivolt samples.
`timescale 1ns / 1ps
`default_nettype none

interface bcv_in_if;
  logic                     valid;
  logic                     ready;
  logic [bcv_pkg::MV_W-1:0] millivolts;

  modport source (output valid, output millivolts, input ready);
  modport sink   (input valid, input millivolts, output ready);
endinterface

`default_nettype wire

// ----- design/bcv_out_if.sv -----
// Channel interface that carries state of charge results.
`timescale 1ns / 1ps
`default_nettype none

interface bcv_out_if;
  logic                      valid;
  logic                      ready;
  logic [bcv_pkg::PCT_W-1:0] charge_percent;

  modport source (output valid, output charge_percent, input ready);
  modport sink   (input valid, input charge_percent, output ready);
endinterface

`default_nettype wire

// ----- design/bcv_front.sv -----
// Front end: accepts samples and classifies them against the curve segments.
`timescale 1ns / 1ps
`default_nettype none

module bcv_front (
  bcv_in_if.sink                 in_ch,
  output bcv_pkg::entry_t        wr_data,
  output logic                   wr_valid,
  input  logic                   wr_ready
);

  logic                       below;
  logic                       above;
  logic                       found;
  logic [bcv_pkg::SEG_W-1:0]  seg;
  bcv_pkg::mv_t               base_mv;
  bcv_pkg::mv_t               diff_mv;

  always_comb begin
    below = (in_ch.millivolts <= bcv_pkg::CURVE_MV[0]);
    above = (in_ch.millivolts >= bcv_pkg::CURVE_MV[bcv_pkg::CURVE_POINTS-1]);
    found = 1'b0;
    seg   = '0;
    for (int i = 0; i < bcv_pkg::SEGMENTS; i++) begin
      if (!found && (in_ch.millivolts <= bcv_pkg::CURVE_MV[i+1])) begin
        seg   = bcv_pkg::SEG_W'(i);
        found = 1'b1;
      end
    end
    base_mv = bcv_pkg::CURVE_MV[bcv_pkg::PT_W'(seg)];
    diff_mv = in_ch.millivolts - base_mv;
  end

  always_comb begin
    wr_data.seg = seg;
    wr_data.off = diff_mv[bcv_pkg::OFF_W-1:0];
    if (below) begin
      wr_data.kind = bcv_pkg::KIND_LOW;
    end else if (above) begin
      wr_data.kind = bcv_pkg::KIND_HIGH;
    end else begin
      wr_data.kind = bcv_pkg::KIND_SEG;
    end
  end

  assign wr_valid    = in_ch.valid;
  assign in_ch.ready = wr_ready;

endmodule

`default_nettype wire

// ----- design/bcv_queue.sv -----
// Short queue of classified samples between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module bcv_queue #(
  parameter int DEPTH = bcv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bcv_pkg::entry_t  wr_data,
  input  logic             wr_valid,
  output logic             wr_ready,
  output bcv_pkg::entry_t  rd_data,
  output logic             rd_valid,
  input  logic             rd_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcv_pkg::entry_t     slots_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                push;
  logic                pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slots_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/bcv_back.sv -----
// Back end: interpolates within the segment and rounds, over three pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module bcv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bcv_pkg::entry_t  rd_data,
  input  logic             rd_valid,
  output logic             rd_ready,
  bcv_out_if.source        out_ch
);

  logic [bcv_pkg::PT_W-1:0]   lo_idx;
  logic [bcv_pkg::PT_W-1:0]   hi_idx;
  bcv_pkg::pct_t              pa;
  bcv_pkg::pct_t              pb;
  bcv_pkg::pct_t              span;
  bcv_pkg::mv_t               width_mv;
  logic [bcv_pkg::N_W-1:0]    scaled;
  logic [bcv_pkg::N_W-1:0]    numer;
  logic [bcv_pkg::PROD_W-1:0] prod;
  logic [bcv_pkg::PCT_W:0]    sum;
  bcv_pkg::pct_t              out_pct_nxt;

  logic                       s1_valid_r;
  bcv_pkg::kind_t             s1_kind_r;
  bcv_pkg::pct_t              s1_pa_r;
  logic [bcv_pkg::N_W-1:0]    s1_numer_r;
  bcv_pkg::recip_t            s1_recip_r;

  logic                       s2_valid_r;
  bcv_pkg::kind_t             s2_kind_r;
  bcv_pkg::pct_t              s2_pa_r;
  bcv_pkg::pct_t              s2_quot_r;

  logic                       out_valid_r;
  bcv_pkg::pct_t              out_pct_r;

  logic                       adv_out;
  logic                       adv_s2;
  logic                       adv_s1;

  assign adv_out  = !out_valid_r || out_ch.ready;
  assign adv_s2   = !s2_valid_r || adv_out;
  assign adv_s1   = !s1_valid_r || adv_s2;
  assign rd_ready = adv_s1;

  always_comb begin
    lo_idx   = bcv_pkg::PT_W'(rd_data.seg);
    hi_idx   = lo_idx + 1'b1;
    pa       = bcv_pkg::CURVE_PCT[lo_idx];
    pb       = bcv_pkg::CURVE_PCT[hi_idx];
    span     = (pb >= pa) ? (pb - pa) : '0;
    width_mv = bcv_pkg::CURVE_MV[hi_idx] - bcv_pkg::CURVE_MV[lo_idx];
    scaled   = bcv_pkg::N_W'(span) * bcv_pkg::N_W'(rd_data.off);
    numer    = (scaled << 1) + bcv_pkg::N_W'(width_mv);
  end

  assign prod = bcv_pkg::PROD_W'(s1_numer_r) * bcv_pkg::PROD_W'(s1_recip_r);

  always_comb begin
    sum = {1'b0, s2_pa_r} + {1'b0, s2_quot_r};
    case (s2_kind_r)
      bcv_pkg::KIND_LOW:  out_pct_nxt = bcv_pkg::PCT_EMPTY;
      bcv_pkg::KIND_HIGH: out_pct_nxt = bcv_pkg::PCT_FULL;
      bcv_pkg::KIND_SEG: begin
        if (sum > {1'b0, bcv_pkg::PCT_FULL}) begin
          out_pct_nxt = bcv_pkg::PCT_FULL;
        end else begin
          out_pct_nxt = sum[bcv_pkg::PCT_W-1:0];
        end
      end
      default:            out_pct_nxt = bcv_pkg::PCT_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_r <= rd_valid;
      end
      if (adv_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_kind_r  <= rd_data.kind;
      s1_pa_r    <= pa;
      s1_numer_r <= numer;
      s1_recip_r <= bcv_pkg::SEG_RECIP[rd_data.seg];
    end
    if (adv_s2) begin
      s2_kind_r <= s1_kind_r;
      s2_pa_r   <= s1_pa_r;
      s2_quot_r <= prod[bcv_pkg::RECIP_SHIFT +: bcv_pkg::PCT_W];
    end
    if (adv_out) begin
      out_pct_r <= out_pct_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.charge_percent = out_pct_r;

endmodule

`default_nettype wire

// ----- design/battery_charge_from_voltage_unit.sv -----
// Top level of the battery state of charge converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts battery voltage samples in millivolts into a state of charge in percent.
// The in_ch channel carries one sample per beat in the millivolts field; the out_ch
// channel returns one beat per sample in the charge_percent field, in the same order.
// The front end classifies each sample against the curve points and places it in a
// short queue; the back end interpolates within the chosen segment in three stages.
// One sample is accepted in every cycle while the queue has room, and one result
// leaves in every cycle while the receiver takes it.
// From the accepting edge, a sample passes through the queue slot and the two multiply
// stages ahead of the output register before its result is shown.
// Reset, synchronous and active low, empties the queue and the pipeline; no result
// is shown during or right after it.
// When the receiver stalls, the result holds, the pipeline fills and then the queue
// fills; in_ch.ready falls only once QUEUE_DEPTH samples are waiting.
module battery_charge_from_voltage_unit #(
  parameter int QUEUE_DEPTH = bcv_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  bcv_in_if.sink      in_ch,
  bcv_out_if.source   out_ch
);

  bcv_pkg::entry_t wr_data;
  logic            wr_valid;
  logic            wr_ready;
  bcv_pkg::entry_t rd_data;
  logic            rd_valid;
  logic            rd_ready;

  bcv_front u_front (
    .in_ch    (in_ch),
    .wr_data  (wr_data),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready)
  );

  bcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (wr_data),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready)
  );

  bcv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- design/bcv_checker.sv -----
// Port-level checks of the battery charge converter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bcv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bcv_pkg::PCT_W-1:0] out_charge_percent
);

  // A result beat held back by the receiver stays and keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_charge_percent))
    else $error("Stalled result beat changed or vanished.");

  // Every result lies within the percentage range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_percent <= bcv_pkg::PCT_FULL)
    else $error("Result beat above one hundred percent.");

  // Reset leaves no result on the output.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  // With an empty pipeline after reset, a sample taken is shown once it has passed the queue slot and the back end.
  assert property (@(posedge clk)
    !rst_n ##1 (rst_n && in_valid && in_ready) |-> ##4 (!rst_n || out_valid ||
      $past(!rst_n) || $past(!rst_n, 2) || $past(!rst_n, 3)))
    else $error("First sample after reset gave no result in time.");

endmodule

bind battery_charge_from_voltage_unit bcv_checker u_bcv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_charge_percent (out_ch.charge_percent)
);

`default_nettype wire
